>>> sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants of the squish-e trajectory compressor
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int PRIO_W = 40;
  localparam int POS_W  = 24;
  localparam int CRD_W  = 32;

  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};
  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

  // configuration register indexes
  localparam logic REG_COMPRESS_RATIO = 1'b0;
  localparam logic REG_ERROR_LIMIT    = 1'b1;

  // input action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_S,
    ST_RD_E,
    ST_RD_M,
    ST_DIV_SET,
    ST_DIV,
    ST_MUL_LAT,
    ST_FIN_LAT,
    ST_MUL_LON,
    ST_FIN_LON,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_SQRT,
    ST_PRIO_WR,
    ST_SRCH_INIT,
    ST_SRCH,
    ST_SRCH_DONE,
    ST_INH_L,
    ST_INH_R,
    ST_REM2,
    ST_SHIFT,
    ST_EMIT_INIT,
    ST_EMIT
  } state_t;

  // where the sequencer goes once a point has been re-scored
  typedef enum logic [1:0] {
    RET_ADD,
    RET_REM2,
    RET_SHIFT
  } ret_t;

endpackage

>>> sv/trajectory_squish_compressor_top.sv
// ----------------------------------------------------------------------------
// trajectory_squish_compressor_top
// squish-e compressor: priority buffer of gps points with sed scoring
// ----------------------------------------------------------------------------
// Input items arrive on in_*: in_tuser low adds the point in in_tdata, high
// finishes the trajectory. Kept points leave on out_* in arrival order, one
// transfer each, out_tlast on the final one. Write registers on cfg_* (always
// ready) only while the block is idle; the block itself does not enforce this.
// One sequencer drives a shared 32x32 multiplier, a radix-2 divider and a
// bit-serial square root. Scoring one point runs 3 reads, set-up, up to 32
// divide steps, 7 multiply and combine steps, 33 root steps and a write. An
// add needs no scoring while fewer than two points are held, else one scoring,
// and once the buffer is at capacity a least-priority scan of one entry a
// cycle, up to two more scorings and a shift; in_tready is low meanwhile. A
// finish repeats scan and removal while the least priority is within
// error_limit, then sends one kept point per cycle that out_tready allows; a
// stalled receiver simply holds the sequencer in the output phase.
// Results are registered, so the next item is taken while the last result
// still waits.
// Reset empties the buffer, sets capacity to its initial value and loads the
// register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module trajectory_squish_compressor_top #(
  parameter int BUFFER_DEPTH     = 32,
  parameter int INITIAL_CAPACITY = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // latitude, longitude, timestamp
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // kept_latitude, kept_longitude, kept_time, kept_position
  output logic         out_tlast,  // last_point
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int INIT_CAP = (INITIAL_CAPACITY > BUFFER_DEPTH) ? BUFFER_DEPTH
                                                              : INITIAL_CAPACITY;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] ICAP_C  = CW'(INIT_CAP);
  localparam int PW = tsc_pkg::PRIO_W;

  // point store
  logic [31:0]                lat_store_r  [BUFFER_DEPTH];
  logic [31:0]                lon_store_r  [BUFFER_DEPTH];
  logic [31:0]                time_store_r [BUFFER_DEPTH];
  logic [tsc_pkg::POS_W-1:0]  pos_store_r  [BUFFER_DEPTH];
  logic [PW-1:0]              prio_store_r [BUFFER_DEPTH];
  logic [PW-1:0]              inh_store_r  [BUFFER_DEPTH];

  tsc_pkg::state_t state_r, state_nxt;
  tsc_pkg::ret_t   ret_r;

  logic [CW-1:0]   held_r, cap_r;
  logic [tsc_pkg::POS_W-1:0] seen_r;
  logic [9:0]      ratio_r;
  logic [31:0]     limit_r;
  logic            fin_r;
  logic            out_valid_r;
  logic [119:0]    out_data_r;
  logic            out_last_r;

  logic [IW-1:0]   s_idx_r, m_idx_r, e_idx_r, k_r, idx_r;
  logic [5:0]      cnt_r;
  logic [PW-1:0]   best_p_r, inh_m_r;
  logic [31:0]     lat_s_r, lon_s_r, t_s_r, lat_e_r, lon_e_r, t_e_r;
  logic [31:0]     lat_m_r, lon_m_r, t_m_r;
  logic [31:0]     r_r, div_rem_r, div_den_r, a_r, b_r;
  logic            r_one_r;
  logic [63:0]     prod_r;
  logic [64:0]     sum_r;
  logic [65:0]     sq_x_r;
  logic [35:0]     sq_rem_r;
  logic [32:0]     sq_res_r;

  // combinational
  logic [IW-1:0]   rd_idx;
  logic [31:0]     rd_lat, rd_lon, rd_time;
  logic [tsc_pkg::POS_W-1:0] rd_pos;
  logic [PW-1:0]   rd_prio, rd_inh;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic            in_acc, out_acc, cfg_acc, out_free;
  logic [9:0]      ratio_eff;
  logic [CW+9:0]   cap_prod;
  logic            cap_grow;
  logic signed [32:0] num, den;
  logic            div_one, div_zero;
  logic [32:0]     div_sh;
  logic            div_ge;
  logic [35:0]     sq_sh, sq_trial;
  logic            sq_ge;
  logic [PW:0]     psum;
  logic [PW-1:0]   p_new;
  logic [CW-1:0]   k_ext, idx_ext;
  logic            k_ge2, k2_lt_held, srch_last, emit_last;

  function automatic logic [31:0] coord_mag(input logic [31:0] cs, input logic [31:0] ce);
    logic signed [32:0] d;
    logic signed [32:0] nd;
    begin
      d  = $signed({ce[31], ce}) - $signed({cs[31], cs});
      nd = -d;
      coord_mag = d[32] ? nd[31:0] : d[31:0];
    end
  endfunction

  // distance from the point to the interpolated coordinate
  function automatic logic [31:0] coord_dist(input logic [31:0] cs, input logic [31:0] ce,
                                             input logic [31:0] cm, input logic one,
                                             input logic [63:0] prod);
    logic signed [32:0] d;
    logic [31:0]        mag, off;
    logic [63:0]        rnd;
    logic signed [34:0] ip, dd, ndd;
    begin
      d   = $signed({ce[31], ce}) - $signed({cs[31], cs});
      mag = coord_mag(cs, ce);
      rnd = prod + 64'h0000_0000_8000_0000;
      off = one ? mag : rnd[63:32];
      if (d[32]) begin
        ip = $signed({{3{cs[31]}}, cs}) - $signed({3'b000, off});
      end else begin
        ip = $signed({{3{cs[31]}}, cs}) + $signed({3'b000, off});
      end
      dd  = ip - $signed({{3{cm[31]}}, cm});
      ndd = -dd;
      coord_dist = dd[34] ? ndd[31:0] : dd[31:0];
    end
  endfunction

  assign in_acc   = in_tvalid & in_tready;
  assign out_acc  = out_valid_r & out_tready;
  assign cfg_acc  = cfg_valid & cfg_ready;
  assign out_free = ~out_valid_r | out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign rd_lat  = lat_store_r[rd_idx];
  assign rd_lon  = lon_store_r[rd_idx];
  assign rd_time = time_store_r[rd_idx];
  assign rd_pos  = pos_store_r[rd_idx];
  assign rd_prio = prio_store_r[rd_idx];
  assign rd_inh  = inh_store_r[rd_idx];

  assign mul_p = mul_a * mul_b;

  // capacity grows when points_seen / ratio >= capacity, i.e. seen >= cap * ratio, up to BUFFER_DEPTH
  assign ratio_eff = (ratio_r == 10'd0) ? 10'd1 : ratio_r;
  assign cap_prod  = (CW+10)'(cap_r) * (CW+10)'(ratio_eff);
  assign cap_grow  = (seen_r >= tsc_pkg::POS_W'(cap_prod)) && (cap_r < DEPTH_C);

  assign num = $signed({1'b0, t_m_r}) - $signed({1'b0, t_s_r});
  assign den = $signed({1'b0, t_e_r}) - $signed({1'b0, t_s_r});
  assign div_one  = (den <= 33'sd0) || (num >= den);
  assign div_zero = (num <= 33'sd0);

  assign div_sh = {div_rem_r, 1'b0};
  assign div_ge = div_sh >= {1'b0, div_den_r};

  assign sq_sh    = {sq_rem_r[33:0], sq_x_r[65:64]};
  assign sq_trial = {1'b0, sq_res_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  assign psum  = {1'b0, inh_m_r} + (PW+1)'(sq_res_r);
  assign p_new = psum[PW] ? tsc_pkg::PRIO_MAX : psum[PW-1:0];

  assign k_ext      = CW'(k_r);
  assign idx_ext    = CW'(idx_r);
  assign k_ge2      = k_ext >= CW'(2);
  assign k2_lt_held = (k_ext + CW'(2)) < held_r;
  assign srch_last  = (idx_ext + CW'(2)) == held_r;
  assign emit_last  = (idx_ext + CW'(1)) == held_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == tsc_pkg::ACT_FINISH) begin
            state_nxt = (held_r >= CW'(3)) ? tsc_pkg::ST_SRCH_INIT : tsc_pkg::ST_EMIT_INIT;
          end else if (held_r < DEPTH_C && held_r >= CW'(2)) begin
            state_nxt = tsc_pkg::ST_RD_S;
          end
        end
      end
      tsc_pkg::ST_RD_S:    state_nxt = tsc_pkg::ST_RD_E;
      tsc_pkg::ST_RD_E:    state_nxt = tsc_pkg::ST_RD_M;
      tsc_pkg::ST_RD_M:    state_nxt = tsc_pkg::ST_DIV_SET;
      tsc_pkg::ST_DIV_SET: begin
        state_nxt = (div_one || div_zero) ? tsc_pkg::ST_MUL_LAT : tsc_pkg::ST_DIV;
      end
      tsc_pkg::ST_DIV: begin
        if (cnt_r == 6'd31) state_nxt = tsc_pkg::ST_MUL_LAT;
      end
      tsc_pkg::ST_MUL_LAT: state_nxt = tsc_pkg::ST_FIN_LAT;
      tsc_pkg::ST_FIN_LAT: state_nxt = tsc_pkg::ST_MUL_LON;
      tsc_pkg::ST_MUL_LON: state_nxt = tsc_pkg::ST_FIN_LON;
      tsc_pkg::ST_FIN_LON: state_nxt = tsc_pkg::ST_MUL_A;
      tsc_pkg::ST_MUL_A:   state_nxt = tsc_pkg::ST_MUL_B;
      tsc_pkg::ST_MUL_B:   state_nxt = tsc_pkg::ST_SUM;
      tsc_pkg::ST_SUM:     state_nxt = tsc_pkg::ST_SQRT;
      tsc_pkg::ST_SQRT: begin
        if (cnt_r == 6'd32) state_nxt = tsc_pkg::ST_PRIO_WR;
      end
      tsc_pkg::ST_PRIO_WR: begin
        unique case (ret_r)
          tsc_pkg::RET_ADD: begin
            state_nxt = (held_r >= cap_r) ? tsc_pkg::ST_SRCH_INIT : tsc_pkg::ST_IDLE;
          end
          tsc_pkg::RET_REM2:  state_nxt = tsc_pkg::ST_REM2;
          tsc_pkg::RET_SHIFT: state_nxt = tsc_pkg::ST_SHIFT;
          default:            state_nxt = tsc_pkg::ST_IDLE;
        endcase
      end
      tsc_pkg::ST_SRCH_INIT: state_nxt = tsc_pkg::ST_SRCH;
      tsc_pkg::ST_SRCH: begin
        if (srch_last) state_nxt = tsc_pkg::ST_SRCH_DONE;
      end
      tsc_pkg::ST_SRCH_DONE: begin
        if (fin_r && best_p_r > PW'(limit_r)) begin
          state_nxt = tsc_pkg::ST_EMIT_INIT;
        end else begin
          state_nxt = tsc_pkg::ST_INH_L;
        end
      end
      tsc_pkg::ST_INH_L: state_nxt = tsc_pkg::ST_INH_R;
      tsc_pkg::ST_INH_R: state_nxt = k_ge2 ? tsc_pkg::ST_RD_S : tsc_pkg::ST_REM2;
      tsc_pkg::ST_REM2:  state_nxt = k2_lt_held ? tsc_pkg::ST_RD_S : tsc_pkg::ST_SHIFT;
      tsc_pkg::ST_SHIFT: begin
        if (!fin_r) begin
          state_nxt = tsc_pkg::ST_IDLE;
        end else if (held_r >= CW'(4)) begin
          state_nxt = tsc_pkg::ST_SRCH_INIT;
        end else begin
          state_nxt = tsc_pkg::ST_EMIT_INIT;
        end
      end
      tsc_pkg::ST_EMIT_INIT: begin
        state_nxt = (held_r == CW'(0)) ? tsc_pkg::ST_IDLE : tsc_pkg::ST_EMIT;
      end
      tsc_pkg::ST_EMIT: begin
        if (out_free && emit_last) state_nxt = tsc_pkg::ST_IDLE;
      end
      default: state_nxt = tsc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: read address, multiplier operands, ready
  always_comb begin
    in_tready = (state_r == tsc_pkg::ST_IDLE);
    rd_idx    = idx_r;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    unique case (state_r)
      tsc_pkg::ST_RD_S:  rd_idx = s_idx_r;
      tsc_pkg::ST_RD_E:  rd_idx = e_idx_r;
      tsc_pkg::ST_RD_M:  rd_idx = m_idx_r;
      tsc_pkg::ST_INH_L: rd_idx = k_r - IW'(1);
      tsc_pkg::ST_INH_R: rd_idx = k_r + IW'(1);
      tsc_pkg::ST_MUL_LAT: begin
        mul_a = coord_mag(lat_s_r, lat_e_r);
        mul_b = r_r;
      end
      tsc_pkg::ST_MUL_LON: begin
        mul_a = coord_mag(lon_s_r, lon_e_r);
        mul_b = r_r;
      end
      tsc_pkg::ST_MUL_A: begin
        mul_a = a_r;
        mul_b = a_r;
      end
      tsc_pkg::ST_MUL_B: begin
        mul_a = b_r;
        mul_b = b_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsc_pkg::ST_IDLE;
      held_r      <= '0;
      cap_r       <= ICAP_C;
      seen_r      <= '0;
      ratio_r     <= 10'd2;
      limit_r     <= 32'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          tsc_pkg::REG_COMPRESS_RATIO: ratio_r <= cfg_data[9:0];
          tsc_pkg::REG_ERROR_LIMIT:    limit_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_acc && !(state_r == tsc_pkg::ST_EMIT && out_free)) out_valid_r <= 1'b0;
      unique case (state_r)
        tsc_pkg::ST_IDLE: begin
          if (in_acc) begin
            fin_r <= (in_tuser == tsc_pkg::ACT_FINISH);
            if (in_tuser == tsc_pkg::ACT_ADD) begin
              if (cap_grow) cap_r <= cap_r + CW'(1);
              if (held_r < DEPTH_C) begin
                held_r <= held_r + CW'(1);
                if (seen_r != tsc_pkg::POS_MAX) seen_r <= seen_r + 1'b1;
              end
            end
          end
        end
        tsc_pkg::ST_SHIFT: held_r <= held_r - CW'(1);
        tsc_pkg::ST_EMIT_INIT: begin
          if (held_r == CW'(0)) begin
            seen_r <= '0;
            cap_r  <= ICAP_C;
          end
        end
        tsc_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (emit_last) begin
              held_r <= '0;
              seen_r <= '0;
              cap_r  <= ICAP_C;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      tsc_pkg::ST_IDLE: begin
        if (in_acc && in_tuser == tsc_pkg::ACT_ADD) begin
          // new point at held-1 after the add; re-score the one before it
          s_idx_r <= IW'(held_r - CW'(2));
          m_idx_r <= IW'(held_r - CW'(1));
          e_idx_r <= IW'(held_r);
          ret_r   <= tsc_pkg::RET_ADD;
        end
      end
      tsc_pkg::ST_RD_S: begin
        lat_s_r <= rd_lat;
        lon_s_r <= rd_lon;
        t_s_r   <= rd_time;
      end
      tsc_pkg::ST_RD_E: begin
        lat_e_r <= rd_lat;
        lon_e_r <= rd_lon;
        t_e_r   <= rd_time;
      end
      tsc_pkg::ST_RD_M: begin
        lat_m_r <= rd_lat;
        lon_m_r <= rd_lon;
        t_m_r   <= rd_time;
        inh_m_r <= rd_inh;
      end
      tsc_pkg::ST_DIV_SET: begin
        r_one_r   <= div_one;
        r_r       <= 32'd0;
        div_rem_r <= num[31:0];
        div_den_r <= den[31:0];
        cnt_r     <= '0;
      end
      tsc_pkg::ST_DIV: begin
        // restoring divide, one quotient bit a step
        div_rem_r <= div_ge ? 32'(div_sh - {1'b0, div_den_r}) : div_sh[31:0];
        r_r       <= {r_r[30:0], div_ge};
        cnt_r     <= cnt_r + 6'd1;
      end
      tsc_pkg::ST_MUL_LAT: prod_r <= mul_p;
      tsc_pkg::ST_FIN_LAT: a_r <= coord_dist(lat_s_r, lat_e_r, lat_m_r, r_one_r, prod_r);
      tsc_pkg::ST_MUL_LON: prod_r <= mul_p;
      tsc_pkg::ST_FIN_LON: b_r <= coord_dist(lon_s_r, lon_e_r, lon_m_r, r_one_r, prod_r);
      tsc_pkg::ST_MUL_A:   prod_r <= mul_p;
      tsc_pkg::ST_MUL_B: begin
        sum_r  <= {1'b0, prod_r};
        prod_r <= mul_p;
      end
      tsc_pkg::ST_SUM: begin
        sq_x_r   <= {1'b0, sum_r + {1'b0, prod_r}};
        sq_rem_r <= '0;
        sq_res_r <= '0;
        cnt_r    <= '0;
      end
      tsc_pkg::ST_SQRT: begin
        // two radicand bits a step
        sq_rem_r <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        sq_res_r <= {sq_res_r[31:0], sq_ge};
        sq_x_r   <= {sq_x_r[63:0], 2'b00};
        cnt_r    <= cnt_r + 6'd1;
      end
      tsc_pkg::ST_SRCH_INIT: idx_r <= IW'(1);
      tsc_pkg::ST_SRCH: begin
        if (idx_r == IW'(1) || rd_prio < best_p_r) begin
          best_p_r <= rd_prio;
          k_r      <= idx_r;
        end
        idx_r <= idx_r + IW'(1);
      end
      tsc_pkg::ST_INH_R: begin
        s_idx_r <= k_r - IW'(2);
        m_idx_r <= k_r - IW'(1);
        e_idx_r <= k_r + IW'(1);
        ret_r   <= tsc_pkg::RET_REM2;
      end
      tsc_pkg::ST_REM2: begin
        s_idx_r <= k_r - IW'(1);
        m_idx_r <= k_r + IW'(1);
        e_idx_r <= k_r + IW'(2);
        ret_r   <= tsc_pkg::RET_SHIFT;
      end
      tsc_pkg::ST_EMIT_INIT: idx_r <= '0;
      tsc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data_r <= {rd_pos, rd_time, rd_lon, rd_lat};
          out_last_r <= emit_last;
          idx_r      <= idx_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  // point store writes
  always_ff @(posedge clk) begin
    unique case (state_r)
      tsc_pkg::ST_IDLE: begin
        if (in_acc && in_tuser == tsc_pkg::ACT_ADD && held_r < DEPTH_C) begin
          lat_store_r[IW'(held_r)]  <= in_tdata[31:0];
          lon_store_r[IW'(held_r)]  <= in_tdata[63:32];
          time_store_r[IW'(held_r)] <= in_tdata[95:64];
          pos_store_r[IW'(held_r)]  <= seen_r;
          prio_store_r[IW'(held_r)] <= tsc_pkg::PRIO_MAX;
          inh_store_r[IW'(held_r)]  <= '0;
        end
      end
      tsc_pkg::ST_PRIO_WR: prio_store_r[m_idx_r] <= p_new;
      tsc_pkg::ST_INH_L: begin
        if (rd_inh < best_p_r) inh_store_r[rd_idx] <= best_p_r;
      end
      tsc_pkg::ST_INH_R: begin
        if (rd_inh < best_p_r) inh_store_r[rd_idx] <= best_p_r;
      end
      tsc_pkg::ST_SHIFT: begin
        // close the gap left by the removed point
        for (int i = 0; i < BUFFER_DEPTH - 1; i++) begin
          if (IW'(i) >= k_r) begin
            lat_store_r[i]  <= lat_store_r[i+1];
            lon_store_r[i]  <= lon_store_r[i+1];
            time_store_r[i] <= time_store_r[i+1];
            pos_store_r[i]  <= pos_store_r[i+1];
            prio_store_r[i] <= prio_store_r[i+1];
            inh_store_r[i]  <= inh_store_r[i+1];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
